// File: rtl/ovq_pkg.sv
// Shared definitions for the overwriting ring queue: field widths, operation
// and status codes, and the default values of the top-level parameters.
// No dependencies.
package ovq_pkg;

    localparam int DATA_W        = 64;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int CNT_W         = 5;

    localparam int DEPTH_DEF     = 16;
    localparam int ELEM_W_DEF    = 64;
    localparam int QSIZE_RESET   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_GET   = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERWRITE = 2'd1,
        ST_EMPTY     = 2'd2
    } t_status;

    // Result fields that wait in the stage between the memory read and the
    // output register.
    typedef struct packed {
        t_status            status;
        logic               has_data;
        logic [CNT_W-1:0]   count;
        logic               empty;
        logic               full;
    } t_res;

endpackage

// File: rtl/overwriting_ring_queue.sv
// Overwriting ring queue: one element memory with head/tail pointers and a
// fill count held in registers, followed by a read stage and an output register.
// Depends on ovq_pkg.
//
// Usage: each input beat on i_valid/o_stall carries one operation in i_op
// (write, get, pop or clear) and, for a write, the element in i_data_in.
// Every input beat yields exactly one output beat on o_valid/i_stall with a
// status, the element read by a successful get (zero otherwise), the fill
// count after the operation and the empty and full flags.
// An accepted beat passes the read stage and the output register to o_valid. The
// pointer and count update happen in the accept cycle and the element memory has
// a single synchronous port, so one operation is accepted every cycle while
// o_stall is low; the read stage and the output register let a new beat enter
// while a result waits. When the receiver holds i_stall, the result stays in the
// output register, the read stage fills behind it and o_stall rises until it drains.
// The queue size register is written through i_cfg_we/i_cfg_data; a write
// also empties the queue. A size of zero acts as one, a size above the
// storage depth acts as the depth.
// Reset empties the queue and sets the size to 16, or to the storage depth if
// that is smaller; the element memory keeps its contents and needs no clearing pass.
module overwriting_ring_queue #(
    parameter int DEPTH      = ovq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = ovq_pkg::ELEM_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ovq_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ovq_pkg::OP_W-1:0]      i_op,
    input  logic [ovq_pkg::DATA_W-1:0]    i_data_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ovq_pkg::STATUS_W-1:0]  o_status,
    output logic [ovq_pkg::DATA_W-1:0]    o_data_out,
    output logic [ovq_pkg::CNT_W-1:0]     o_fill_count,
    output logic                          o_is_empty,
    output logic                          o_is_full
);
    import ovq_pkg::*;

    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CmpW       = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int MaxSizeInt = (DEPTH < 31) ? DEPTH : 31;
    localparam logic [CNT_W-1:0] MaxSize   = CNT_W'(MaxSizeInt);
    localparam logic [CNT_W-1:0] SizeReset =
        (QSIZE_RESET > MaxSizeInt) ? MaxSize : CNT_W'(QSIZE_RESET);

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    logic [CNT_W-1:0]      r_size;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_s1_valid;
    t_res                  r_s1, n_s1;
    logic [ELEM_WIDTH-1:0] r_rd_data;
    logic                  r_o_valid;
    t_res                  r_o;
    logic [DATA_W-1:0]     r_o_data;

    logic                  in_acc;
    logic                  s1_move;
    logic                  mem_we;
    logic                  mem_re;
    logic [CNT_W-1:0]      cfg_size;
    logic [AW-1:0]         head_adv;
    logic [AW-1:0]         tail_adv;
    t_op                   op;

    // Wrap an index back to zero when it reaches the effective size.
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                              input logic [CNT_W-1:0] size);
        logic [CmpW-1:0] nxt;
        nxt = CmpW'(p) + CmpW'(1);
        return (nxt >= CmpW'(size)) ? '0 : AW'(nxt);
    endfunction

    assign op       = t_op'(i_op);
    assign s1_move  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall  = r_s1_valid && !s1_move;
    assign in_acc   = i_valid && !o_stall;
    assign head_adv = advance(r_head, r_size);
    assign tail_adv = advance(r_tail, r_size);

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = CNT_W'(1);
        end else if (i_cfg_data > MaxSize) begin
            cfg_size = MaxSize;
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    always_comb begin
        n_head          = r_head;
        n_tail          = r_tail;
        n_count         = r_count;
        n_s1.status     = ST_OK;
        n_s1.has_data   = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        unique case (op)
            OP_WRITE: begin
                mem_we = 1'b1;
                n_tail = tail_adv;
                if (r_count >= r_size) begin
                    // Full: the oldest entry goes, so the count stays put.
                    n_head      = head_adv;
                    n_s1.status = ST_OVERWRITE;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_GET: begin
                if (r_count == '0) begin
                    n_s1.status = ST_EMPTY;
                end else begin
                    mem_re        = 1'b1;
                    n_s1.has_data = 1'b1;
                    n_head        = head_adv;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            OP_POP: begin
                if (r_count != '0) begin
                    n_head  = head_adv;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
                n_head = r_head;
            end
        endcase
        n_s1.count = n_count;
        n_s1.empty = (n_count == '0);
        n_s1.full  = (n_count == r_size);
    end

    // Element memory. One operation per cycle uses at most one port, and a
    // read never targets an entry written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            mem[r_tail] <= i_data_in[ELEM_WIDTH-1:0];
        end
        if (in_acc && mem_re) begin
            r_rd_data <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SizeReset;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_size  <= cfg_size;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (in_acc) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_o      <= r_s1;
            r_o_data <= r_s1.has_data ? DATA_W'(r_rd_data) : '0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o.status;
    assign o_data_out   = r_o_data;
    assign o_fill_count = r_o.count;
    assign o_is_empty   = r_o.empty;
    assign o_is_full    = r_o.full;

    a_count_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_size)
        else $error("fill count above queue size");

    a_ptr_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CmpW'(r_head) < CmpW'(r_size)) && (CmpW'(r_tail) < CmpW'(r_size)))
        else $error("pointer beyond queue size");

    a_get_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (op == OP_GET) && (r_count != '0))
            |=> (r_s1_valid && r_s1.has_data))
        else $error("get on a filled queue did not schedule a read");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o.status == ST_EMPTY)) |-> (r_o_data == '0))
        else $error("get on empty queue returned data");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ((r_o.empty == (r_o.count == '0)) && !(r_o.empty && r_o.full)))
        else $error("inconsistent empty and full flags");

endmodule
